// File: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// Package for the great-circle distance pipeline: widths, fixed-point constants,
// the CORDIC arctangent table and the angle conversion helpers. No dependencies.
package gcd_pkg;

   localparam int AngleFracBits = 20;
   localparam int CordicStages  = 24;
   localparam int LatWidth      = 28;
   localparam int LonWidth      = 29;
   localparam int DistWidth     = 29;
   localparam int SqrtSteps     = 31;
   localparam int Depth         = 4 + (CordicStages + 1) + 4 + (SqrtSteps + 1)
                                  + (CordicStages + 1) + 3;

   localparam logic signed [33:0] GainQ30 = 34'sd652032874;
   localparam logic signed [33:0] Q30One  = 34'sd1073741824;
   localparam logic [32:0] RpiQ8   = 33'd5123862220;

   // A turn is 360 * 2^20 = 45 * 2^23 input units, so the binary angle is the
   // magnitude shifted by 8 or 9 bits, plus half of 45, divided by 45.
   localparam logic [37:0] TurnBias  = 38'd22;
   localparam logic [5:0]  TurnDiv   = 6'd45;
   localparam logic [22:0] TurnRecip = 23'd5965233;

   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] v;
      begin
         unique case (idx)
            0: v = 34'sh20000000; 1: v = 34'sh12E4051E; 2: v = 34'sh09FB385B;
            3: v = 34'sh051111D4; 4: v = 34'sh028B0D43; 5: v = 34'sh0145D7E1;
            6: v = 34'sh00A2F61E; 7: v = 34'sh00517C55; 8: v = 34'sh0028BE53;
            9: v = 34'sh00145F2F; 10: v = 34'sh000A2F98; 11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6; 13: v = 34'sh000145F3; 14: v = 34'sh0000A2F9;
            15: v = 34'sh0000517C; 16: v = 34'sh000028BE; 17: v = 34'sh0000145F;
            18: v = 34'sh00000A2F; 19: v = 34'sh00000517; 20: v = 34'sh0000028B;
            21: v = 34'sh00000145; 22: v = 34'sh000000A2; 23: v = 34'sh00000051;
            24: v = 34'sh00000028; 25: v = 34'sh00000014; 26: v = 34'sh0000000A;
            27: v = 34'sh00000005; 28: v = 34'sh00000002; 29: v = 34'sh00000001;
            default: v = 34'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

// File: rtl/gcd_sincos.sv
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one stage per register, converts a binary
// angle into sine and cosine in Q30. Uses gcd_pkg.
module gcd_sincos (
   input  logic                clock,
   input  logic [31:0]         angle,
   output logic signed [33:0]  sin_q30,
   output logic signed [33:0]  cos_q30
);
   import gcd_pkg::*;

   logic signed [33:0] x_ff [0:CordicStages];
   logic signed [33:0] y_ff [0:CordicStages];
   logic signed [33:0] z_ff [0:CordicStages];
   logic               neg_ff [0:CordicStages];
   logic signed [33:0] z_start;
   logic signed [33:0] z_in;
   logic               neg_in;

   always_comb begin
      z_start = {{2{angle[31]}}, angle};
      z_in    = z_start;
      neg_in  = 1'b0;
      if (z_start > Q30One) begin
         z_in   = z_start - 34'sd2147483648;
         neg_in = 1'b1;
      end else if (z_start < -Q30One) begin
         z_in   = z_start + 34'sd2147483648;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= GainQ30;
      y_ff[0]   <= 34'sd0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar i = 0; i < CordicStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_entry(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_entry(i);
         end
      end
   end

   assign sin_q30 = neg_ff[CordicStages] ? -y_ff[CordicStages] : y_ff[CordicStages];
   assign cos_q30 = neg_ff[CordicStages] ? -x_ff[CordicStages] : x_ff[CordicStages];
endmodule

// File: rtl/gcd_sqrt.sv
`timescale 1ns / 1ps
// Pipelined restoring square root of a 62-bit value, one result bit per stage,
// giving the floor root. Uses gcd_pkg.
module gcd_sqrt (
   input  logic        clock,
   input  logic [61:0] radicand,
   output logic [30:0] root
);
   import gcd_pkg::*;

   logic [61:0] rem_ff [0:SqrtSteps];
   logic [30:0] res_ff [0:SqrtSteps];

   always_ff @(posedge clock) begin
      rem_ff[0] <= radicand;
      res_ff[0] <= '0;
   end

   for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
      localparam int Bt = SqrtSteps - 1 - i;
      logic [62:0] trial;
      assign trial = ({32'd0, res_ff[i]} << (Bt + 1)) + (63'd1 << (2 * Bt));
      always_ff @(posedge clock) begin
         if ({1'b0, rem_ff[i]} >= trial) begin
            rem_ff[i+1] <= rem_ff[i] - trial[61:0];
            res_ff[i+1] <= res_ff[i] | (31'd1 << Bt);
         end else begin
            rem_ff[i+1] <= rem_ff[i];
            res_ff[i+1] <= res_ff[i];
         end
      end
   end

   assign root = res_ff[SqrtSteps];
endmodule

// File: rtl/gcd_atan2.sv
`timescale 1ns / 1ps
// Pipelined vectoring-mode CORDIC: one stage per register, gives the angle of
// (x, y) as a binary angle. Uses gcd_pkg.
module gcd_atan2 (
   input  logic               clock,
   input  logic [30:0]        y_val,
   input  logic [30:0]        x_val,
   output logic signed [33:0] angle
);
   import gcd_pkg::*;

   logic signed [33:0] x_ff [0:CordicStages];
   logic signed [33:0] y_ff [0:CordicStages];
   logic signed [33:0] z_ff [0:CordicStages];

   always_ff @(posedge clock) begin
      x_ff[0] <= {3'd0, x_val};
      y_ff[0] <= {3'd0, y_val};
      z_ff[0] <= 34'sd0;
   end

   for (genvar i = 0; i < CordicStages; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (!y_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_entry(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_entry(i);
         end
      end
   end

   assign angle = z_ff[CordicStages];
endmodule

// File: rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// Top level of the haversine great-circle distance pipeline.
// Uses gcd_pkg, gcd_sincos, gcd_sqrt and gcd_atan2.
//
//   channel | ports                          | handshake
//   input   | req_lat/lon_first/second       | start high, busy low
//   result  | rsp_distance                   | rsp_valid strobe, one cycle
//
// A beat is taken every cycle; busy is always low. The result of a beat is
// shown with rsp_valid after the Depth pipeline registers: angle conversion,
// the sine and cosine CORDIC, the haversine sum, the square root, the
// arctangent CORDIC and the final scaling.
// Reset clears only the valid bits. The receiver cannot stall, so the
// pipeline never stops.
module great_circle_distance (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [gcd_pkg::LatWidth-1:0]  req_lat_first,
   input  logic signed [gcd_pkg::LonWidth-1:0]  req_lon_first,
   input  logic signed [gcd_pkg::LatWidth-1:0]  req_lat_second,
   input  logic signed [gcd_pkg::LonWidth-1:0]  req_lon_second,
   output logic                                 rsp_valid,
   output logic [gcd_pkg::DistWidth-1:0]        rsp_distance
);
   import gcd_pkg::*;

   // Stage 1: differences. Stages 2 to 4: scaling, then a divide by 45 in two
   // 16-bit digits by reciprocal multiplication, and the sign put back.
   logic signed [30:0] dlat_ff, dlon_ff, lat1_ff, lat2_ff;
   logic [37:0] scaled_ff [0:3];
   logic [21:0] part_ff [0:3];
   logic [15:0] qhi_ff [0:3];
   logic [21:0] div_hi [0:3];
   logic [21:0] div_lo [0:3];
   logic [3:0]  nsg_ff, nsg2_ff;
   logic [31:0] bam_ff [0:3];
   logic [Depth-1:0] valid_ff;

   function automatic logic [37:0] turn_scaled(input logic signed [30:0] v,
                                               input logic half);
      logic [30:0] m;
      begin
         m = v[30] ? -v : v;
         return half ? ({7'd0, m} << 8) + TurnBias : ({7'd0, m} << 9) + TurnBias;
      end
   endfunction

   // Returns the quotient by 45 in the upper 16 bits and the remainder below.
   function automatic logic [21:0] div45(input logic [21:0] v);
      logic [44:0] p;
      logic [15:0] q;
      logic [21:0] back;
      logic [21:0] rem;
      begin
         p    = {23'd0, v} * {22'd0, TurnRecip};
         q    = p[43:28];
         back = {6'd0, q} * {16'd0, TurnDiv};
         rem  = v - back;
         return {q, rem[5:0]};
      end
   endfunction

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         div_hi[k] = div45({scaled_ff[k][37:32], scaled_ff[k][31:16]});
         div_lo[k] = div45(part_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      dlat_ff <= 31'(req_lat_second) - 31'(req_lat_first);
      dlon_ff <= 31'(req_lon_second) - 31'(req_lon_first);
      lat1_ff <= 31'(req_lat_first);
      lat2_ff <= 31'(req_lat_second);
      scaled_ff[0] <= turn_scaled(dlat_ff, 1'b1);
      scaled_ff[1] <= turn_scaled(dlon_ff, 1'b1);
      scaled_ff[2] <= turn_scaled(lat1_ff, 1'b0);
      scaled_ff[3] <= turn_scaled(lat2_ff, 1'b0);
      nsg_ff  <= {lat2_ff[30], lat1_ff[30], dlon_ff[30], dlat_ff[30]};
      nsg2_ff <= nsg_ff;
      for (int k = 0; k < 4; k++) begin
         part_ff[k] <= {div_hi[k][5:0], scaled_ff[k][15:0]};
         qhi_ff[k]  <= div_hi[k][21:6];
         bam_ff[k]  <= nsg2_ff[k] ? 32'd0 - {qhi_ff[k], div_lo[k][21:6]}
                                  : {qhi_ff[k], div_lo[k][21:6]};
      end
   end

   logic signed [33:0] sd, sl, c1, c2, unused_c0, unused_c1, unused_s2, unused_s3;
   gcd_sincos u_sd (.clock, .angle(bam_ff[0]), .sin_q30(sd), .cos_q30(unused_c0));
   gcd_sincos u_sl (.clock, .angle(bam_ff[1]), .sin_q30(sl), .cos_q30(unused_c1));
   gcd_sincos u_c1 (.clock, .angle(bam_ff[2]), .sin_q30(unused_s2), .cos_q30(c1));
   gcd_sincos u_c2 (.clock, .angle(bam_ff[3]), .sin_q30(unused_s3), .cos_q30(c2));

   function automatic logic signed [33:0] mq(input logic signed [33:0] a,
                                             input logic signed [33:0] b);
      logic signed [67:0] p;
      begin
         p = (68'(a) * 68'(b)) + 68'sd536870912;
         return 34'(p >>> 30);
      end
   endfunction

   logic signed [33:0] sdsq_ff, slsq_ff, cc_ff, sdsq2_ff, cs_ff, a_ff;
   logic [30:0] aq_ff;
   always_ff @(posedge clock) begin
      sdsq_ff  <= mq(sd, sd);
      slsq_ff  <= mq(sl, sl);
      cc_ff    <= mq(c1, c2);
      sdsq2_ff <= sdsq_ff;
      cs_ff    <= mq(cc_ff, slsq_ff);
      a_ff     <= sdsq2_ff + cs_ff;
      if (a_ff[33]) aq_ff <= '0;
      else if (a_ff > Q30One) aq_ff <= 31'd1073741824;
      else aq_ff <= a_ff[30:0];
   end

   logic [30:0] ry, rx;
   logic [30:0] naq;
   assign naq = 31'd1073741824 - aq_ff;
   gcd_sqrt u_ry (.clock, .radicand({aq_ff, 31'd0} >> 1), .root(ry));
   gcd_sqrt u_rx (.clock, .radicand({naq, 31'd0} >> 1), .root(rx));

   logic signed [33:0] z;
   gcd_atan2 u_at (.clock, .y_val(ry), .x_val(rx), .angle(z));

   logic [31:0] zc_ff;
   logic [64:0] prod_ff;
   logic [DistWidth-1:0] dist_ff;
   always_ff @(posedge clock) begin
      zc_ff   <= z[33] ? 32'd0 : z[31:0];
      prod_ff <= 65'(zc_ff) * 65'(RpiQ8) + (65'd1 << 33);
      dist_ff <= (prod_ff[64:34] > 31'h1FFFFFFF) ? 29'h1FFFFFFF : prod_ff[62:34];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[Depth-2:0], start};
   end

   assign busy         = 1'b0;
   assign rsp_valid    = valid_ff[Depth-1];
   assign rsp_distance = dist_ff;

   a_busy_low: assert property (@(posedge clock) busy == 1'b0) else $error("busy set");
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_distance)) else $error("distance unknown");
endmodule

// File: tb/great_circle_distance_tb.sv
`timescale 1ns / 1ps
// Testbench for great_circle_distance: directed and random position pairs,
// checked beat by beat against a fixed-point haversine predictor.
// Depends on gcd_pkg and the great_circle_distance RTL.
module great_circle_distance_tb;
   import gcd_pkg::*;

   localparam longint LatSpan  = 94371840;
   localparam longint LonSpan  = 188743680;
   localparam int     Watchdog = 20000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [LatWidth-1:0]  req_lat_first  = '0;
   logic signed [LonWidth-1:0]  req_lon_first  = '0;
   logic signed [LatWidth-1:0]  req_lat_second = '0;
   logic signed [LonWidth-1:0]  req_lon_second = '0;
   logic                        rsp_valid;
   logic [DistWidth-1:0]        rsp_distance;

   logic [DistWidth-1:0] pending_distance[$];
   int                   failures = 0;
   int                   idle_cycles = 0;
   int                   send_idle_pct = 0;
   longint               arc_table[32];

   great_circle_distance dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_lat_first(req_lat_first), .req_lon_first(req_lon_first),
      .req_lat_second(req_lat_second), .req_lon_second(req_lon_second),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance)
   );

   always #6 clock = ~clock;

   initial begin
      arc_table = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
         64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
         64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
         64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
         64'h00000002, 64'h00000001, 64'h00000000, 64'h00000000};
   end

   function automatic logic [31:0] degrees_to_turns(longint deg, int shift);
      longint unsigned mag;
      longint unsigned den;
      logic [31:0]     r;
      mag = (deg < 0) ? longint'(-deg) : longint'(deg);
      den = 64'd360 << AngleFracBits;
      r = 32'(((mag << shift) + den / 2) / den);
      return (deg < 0) ? (32'd0 - r) : r;
   endfunction

   task automatic rotate_unit(input logic [31:0] theta, output longint sin_q30,
                              output longint cos_q30);
      longint x;
      longint y;
      longint z;
      longint nx;
      longint ny;
      bit     flip;
      x = GainQ30;
      y = 0;
      flip = 0;
      z = longint'(theta[30:0]) - (theta[31] ? (64'sd1 <<< 31) : 64'sd0);
      if (z > (64'sd1 <<< 30)) begin
         z -= 64'sd1 <<< 31;
         flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z += 64'sd1 <<< 31;
         flip = 1;
      end
      for (int i = 0; i < CordicStages; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_table[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arc_table[i];
         end
         x = nx;
         y = ny;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin_q30 = y;
      cos_q30 = x;
   endtask

   function automatic longint q30_product(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint central_angle(longint y, longint x);
      longint z;
      longint nx;
      longint ny;
      z = 0;
      for (int i = 0; i < CordicStages; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arc_table[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arc_table[i];
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   task automatic predict_distance(input longint lat1, input longint lon1,
                                   input longint lat2, input longint lon2,
                                   output logic [DistWidth-1:0] dist_out);
      longint          sd, cd, sl, cl, s1, c1, s2, c2, hav;
      longint          z;
      longint unsigned ry, rx, scaled;
      rotate_unit(degrees_to_turns(lat2 - lat1, 31), sd, cd);
      rotate_unit(degrees_to_turns(lon2 - lon1, 31), sl, cl);
      rotate_unit(degrees_to_turns(lat1, 32), s1, c1);
      rotate_unit(degrees_to_turns(lat2, 32), s2, c2);
      hav = q30_product(sd, sd) +
            q30_product(q30_product(c1, c2), q30_product(sl, sl));
      if (hav < 0) hav = 0;
      if (hav > (64'sd1 <<< 30)) hav = 64'sd1 <<< 30;
      ry = root_floor(longint'(hav) << 30);
      rx = root_floor(longint'((64'sd1 <<< 30) - hav) << 30);
      z = central_angle(longint'(ry), longint'(rx));
      if (z < 0) z = 0;
      scaled = (longint'(z) * longint'(RpiQ8) + (64'd1 << 33)) >> 34;
      if (scaled > 64'h1FFFFFFF) scaled = 64'h1FFFFFFF;
      dist_out = scaled[DistWidth-1:0];
   endtask

   always @(posedge clock) begin
      logic [DistWidth-1:0] want;
      if (!reset) begin
         if (start && !busy) begin
            predict_distance(req_lat_first, req_lon_first, req_lat_second,
                             req_lon_second, want);
            pending_distance.push_back(want);
         end
         if (rsp_valid) begin
            if (pending_distance.size() == 0) begin
               $error("unexpected beat: distance %0d", rsp_distance);
               failures++;
            end else begin
               want = pending_distance.pop_front();
               if (rsp_distance !== want) begin
                  $error("distance: expected %0d, actual %0d", want, rsp_distance);
                  failures++;
               end
            end
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= Watchdog) begin
            $display("[great_circle_distance] ERROR");
            $finish;
         end
      end
   end

   task automatic send_pair(input longint lat1, input longint lon1,
                            input longint lat2, input longint lon2);
      while ($urandom_range(99) < send_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_lat_first = lat1[LatWidth-1:0];
      req_lon_first = lon1[LonWidth-1:0];
      req_lat_second = lat2[LatWidth-1:0];
      req_lon_second = lon2[LonWidth-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_distance.size() != 0) @(negedge clock);
   endtask

   function automatic longint rand_span(longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   function automatic longint rand_bits(int w);
      logic [63:0] v;
      v = {$urandom, $urandom};
      return longint'(v << (64 - w)) >>> (64 - w);
   endfunction

   task automatic test_directed();
      longint deg;
      deg = 64'sd1 <<< AngleFracBits;
      send_pair(0, 0, 0, 0);
      send_pair(deg, deg, deg, deg);
      send_pair(0, 0, 0, 180 * deg);
      send_pair(0, -180 * deg, 0, 180 * deg);
      send_pair(90 * deg, 0, -90 * deg, 0);
      send_pair(-90 * deg, 45 * deg, 90 * deg, -135 * deg);
      send_pair(LatSpan, LonSpan, -LatSpan, -LonSpan);
      send_pair(0, 0, 1, 0);
      send_pair(0, 0, 0, 1);
      send_pair(45 * deg, 90 * deg, -45 * deg, -90 * deg);
      send_pair(-(64'sd1 <<< 27), -(64'sd1 <<< 28), (64'sd1 <<< 27) - 1,
                (64'sd1 <<< 28) - 1);
      send_pair((64'sd1 <<< 27) - 1, (64'sd1 <<< 28) - 1, -(64'sd1 <<< 27),
                -(64'sd1 <<< 28));
      send_pair(100 * deg, 0, 100 * deg, 0);
      send_pair(0, 270 * deg, 0, -270 * deg);
      send_pair(10 * deg, 0, 10 * deg, 180 * deg);
      send_pair(51 * deg, 0, 40 * deg, -74 * deg);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int idle_pct);
      longint lat1, lon1, lat2, lon2;
      int     kind;
      send_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(9);
         lat1 = rand_span(LatSpan);
         lon1 = rand_span(LonSpan);
         if (kind < 5) begin
            lat2 = rand_span(LatSpan);
            lon2 = rand_span(LonSpan);
         end else if (kind < 7) begin
            lat2 = lat1 + rand_span(4096);
            lon2 = lon1 + rand_span(4096);
         end else if (kind < 8) begin
            lat2 = -lat1 + rand_span(4096);
            lon2 = lon1 + LonSpan + rand_span(4096);
         end else begin
            lat1 = rand_bits(LatWidth);
            lon1 = rand_bits(LonWidth);
            lat2 = rand_bits(LatWidth);
            lon2 = rand_bits(LonWidth);
         end
         send_pair(lat1, lon1, lat2, lon2);
         if (n == count / 2) wait_drained();
      end
      send_idle_pct = 0;
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(160, 19);
      test_random(160, 82);
      test_random(180, 0);
      wait_drained();
      repeat (Depth + 20) @(negedge clock);
      if (failures == 0) begin
         $display("[great_circle_distance] OK");
      end else begin
         $display("[great_circle_distance] ERROR");
      end
      $finish;
   end

endmodule
